### sv/dasl_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and reset constants of the dual-axis duty slew limiter.
// No dependencies; every other file of the block refers to this package.
package dasl_pkg;

    localparam int NUM_AXES_DEF = 2;
    localparam int DUTY_W       = 16;
    localparam int APP_W        = 17;
    localparam int CFG_W        = 15;
    localparam int LVL_W        = 8;
    localparam int CFG_IDX_W    = 2;

    // item kinds
    localparam logic KIND_REQ  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 2'd2;

    // register and state reset values
    localparam logic [CFG_W-1:0] MIN_DUTY_RST  = 15'd0;
    localparam logic [CFG_W-1:0] MAX_DUTY_RST  = 15'd255;
    localparam logic [CFG_W-1:0] RAMP_STEP_RST = 15'd1;

    typedef struct packed {
        logic                     kind;
        logic                     axis;
        logic signed [DUTY_W-1:0] req_duty;
        logic                     req_dir;
    } t_in_item;

    typedef struct packed {
        logic             out_axis;
        logic             out_dir;
        logic [LVL_W-1:0] forward_level;
        logic [LVL_W-1:0] reverse_level;
        logic             last;
    } t_out_item;

    // per-axis drive result captured on a tick
    typedef struct packed {
        logic             dir;
        logic [LVL_W-1:0] level;
    } t_res_ent;

endpackage

### sv/dasl_axis.sv
`timescale 1ns / 1ps
// Per-axis tick logic: request clamp, duty ramp with direction reversal, drive level.
// Depends on dasl_pkg.
module dasl_axis (
    input  logic signed [dasl_pkg::DUTY_W-1:0] i_req_duty,
    input  logic                               i_req_dir,
    input  logic signed [dasl_pkg::APP_W-1:0]  i_app_duty,
    input  logic                               i_app_dir,
    input  logic        [dasl_pkg::CFG_W-1:0]  i_lo,
    input  logic        [dasl_pkg::CFG_W-1:0]  i_hi,
    input  logic        [dasl_pkg::CFG_W-1:0]  i_step,
    output logic signed [dasl_pkg::DUTY_W-1:0] o_req_duty,
    output logic signed [dasl_pkg::APP_W-1:0]  o_app_duty,
    output logic                               o_app_dir,
    output dasl_pkg::t_res_ent                 o_res
);

    function automatic logic signed [17:0] f_clamp(input logic signed [17:0] v,
                                                   input logic signed [17:0] lo,
                                                   input logic signed [17:0] hi);
        logic signed [17:0] r;
        r = v;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

    logic signed [17:0] lo, hi, step, req, cur, rq, up, dn, nx, lvl;
    logic               ndir;

    assign lo   = signed'({3'b000, i_lo});
    assign hi   = signed'({3'b000, i_hi});
    assign step = signed'({3'b000, i_step});
    assign req  = signed'({{2{i_req_duty[15]}}, i_req_duty});
    assign cur  = signed'({i_app_duty[16], i_app_duty});

    // minimum is tested before maximum, so max wins when the two cross
    assign rq = f_clamp(req, lo, hi);
    assign up = rq - cur;
    assign dn = cur - rq;

    always_comb begin
        nx   = cur;
        ndir = i_app_dir;
        if (i_req_dir != i_app_dir) begin
            // wind down first, flip only once at or below the minimum
            if (cur <= lo) begin
                ndir = i_req_dir;
            end else begin
                nx = cur - step;
            end
        end else if (rq > cur) begin
            nx = (up >= step) ? cur + step : rq;
        end else if (rq < cur) begin
            nx = (dn >= step) ? cur - step : rq;
        end
    end

    assign lvl        = f_clamp(nx, lo, hi);
    assign o_req_duty = rq[15:0];
    assign o_app_duty = nx[16:0];
    assign o_app_dir  = ndir;
    assign o_res.dir   = ndir;
    assign o_res.level = lvl[7:0];

endmodule

### sv/dasl_ser.sv
`timescale 1ns / 1ps
// Result serializer: holds one tick's per-axis results and hands them out
// one per cycle unless stalled, by a registered output. Uses dasl_pkg.
module dasl_ser #(
    parameter int NUM_AXES = dasl_pkg::NUM_AXES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  dasl_pkg::t_res_ent   i_ents [NUM_AXES],
    output logic                 o_free,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dasl_pkg::t_out_item  o_out_data
);

    localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam logic [AXW-1:0] LAST_IDX = AXW'(NUM_AXES - 1);

    dasl_pkg::t_res_ent  r_ents [NUM_AXES];
    logic                r_busy;
    logic [AXW-1:0]      r_idx;
    logic                r_out_valid;
    dasl_pkg::t_out_item r_out;
    logic                out_load;
    logic                at_last;

    assign out_load = r_busy && (!r_out_valid || !i_out_stall);
    assign at_last  = (r_idx == LAST_IDX);
    assign o_free   = !r_busy || (out_load && at_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // a new set of results restarts at the first axis
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (out_load) begin
                if (at_last) begin
                    r_busy <= 1'b0;
                    r_idx  <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_axis      <= r_idx[0];
            r_out.out_dir       <= r_ents[0].dir;
            r_out.forward_level <= r_ents[0].dir ? '0 : r_ents[0].level;
            r_out.reverse_level <= r_ents[0].dir ? r_ents[0].level : '0;
            r_out.last          <= at_last;
        end
        if (i_load) begin
            r_ents <= i_ents;
        end else if (out_load) begin
            for (int k = 0; k < NUM_AXES - 1; k++) begin
                r_ents[k] <= r_ents[k + 1];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("serializer loaded while still busy");

    a_load_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_busy && r_idx == '0))
        else $error("serializer did not restart at the first axis");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && at_last) |=> (o_out_valid && o_out_data.last))
        else $error("final axis result not flagged last");

endmodule

### sv/dual_axis_duty_slew_limiter.sv
`timescale 1ns / 1ps
// Dual-axis PWM duty slew limiter, top level. Depends on dasl_pkg, dasl_axis, dasl_ser.
// A tick passes the input register, then the serializer's result store, before its
// first axis result is registered at the output. One request per cycle unless a
// stalled tick holds the input; results leave in turn via the single output register.
// Reset (synchronous, active low): registers to min 0, max 255, step 1;
// all requested and applied duties and directions to zero; no results pending.
module dual_axis_duty_slew_limiter #(
    parameter int NUM_AXES = dasl_pkg::NUM_AXES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  dasl_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dasl_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [dasl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dasl_pkg::CFG_W-1:0]        i_cfg_data
);

    // configuration registers
    logic [dasl_pkg::CFG_W-1:0] r_min, r_max, r_step;

    // input register
    logic               r_in_valid;
    dasl_pkg::t_in_item r_in;

    // per-axis state
    logic signed [dasl_pkg::DUTY_W-1:0] r_req_duty [NUM_AXES];
    logic                               r_req_dir  [NUM_AXES];
    logic signed [dasl_pkg::APP_W-1:0]  r_app_duty [NUM_AXES];
    logic                               r_app_dir  [NUM_AXES];

    // per-axis next values from the tick logic
    logic signed [dasl_pkg::DUTY_W-1:0] n_req_duty [NUM_AXES];
    logic signed [dasl_pkg::APP_W-1:0]  n_app_duty [NUM_AXES];
    logic                               n_app_dir  [NUM_AXES];
    dasl_pkg::t_res_ent                 w_res      [NUM_AXES];

    logic ser_free;
    logic adv;
    logic is_tick;

    // Write a register on enable; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= dasl_pkg::MIN_DUTY_RST;
            r_max  <= dasl_pkg::MAX_DUTY_RST;
            r_step <= dasl_pkg::RAMP_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dasl_pkg::CFG_MIN_DUTY:  r_min  <= i_cfg_data;
                dasl_pkg::CFG_MAX_DUTY:  r_max  <= i_cfg_data;
                dasl_pkg::CFG_RAMP_STEP: r_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The held item advances at once if it is a request; a tick advances only
    // when the serializer can take the new set of axis results.
    assign is_tick    = (r_in.kind == dasl_pkg::KIND_TICK);
    assign adv        = r_in_valid && (!is_tick || ser_free);
    assign o_in_stall = r_in_valid && !adv;

    // Take a transfer whenever the input register is empty or moving on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // One tick unit per axis; a request touches only the addressed axis,
    // and only axes 0 and 1 can be addressed by the one-bit axis field.
    for (genvar A = 0; A < NUM_AXES; A++) begin : g_axis
        localparam logic AXIS_BIT = 1'(A % 2);
        localparam bit   ADDRESSABLE = (A < 2);

        logic wr_req;

        assign wr_req = adv && !is_tick && ADDRESSABLE && (r_in.axis == AXIS_BIT);

        dasl_axis u_axis (
            .i_req_duty (r_req_duty[A]),
            .i_req_dir  (r_req_dir[A]),
            .i_app_duty (r_app_duty[A]),
            .i_app_dir  (r_app_dir[A]),
            .i_lo       (r_min),
            .i_hi       (r_max),
            .i_step     (r_step),
            .o_req_duty (n_req_duty[A]),
            .o_app_duty (n_app_duty[A]),
            .o_app_dir  (n_app_dir[A]),
            .o_res      (w_res[A])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_req_duty[A] <= signed'({1'b0, dasl_pkg::MIN_DUTY_RST});
                r_req_dir[A]  <= 1'b0;
                r_app_duty[A] <= signed'({2'b00, dasl_pkg::MIN_DUTY_RST});
                r_app_dir[A]  <= 1'b0;
            end else if (adv && is_tick) begin
                // clamped request is kept as the new stored request
                r_req_duty[A] <= n_req_duty[A];
                r_app_duty[A] <= n_app_duty[A];
                r_app_dir[A]  <= n_app_dir[A];
            end else if (wr_req) begin
                r_req_duty[A] <= r_in.req_duty;
                r_req_dir[A]  <= r_in.req_dir;
            end
        end
    end

    // Hand the tick's results to the serializer, which drives the output.
    dasl_ser #(
        .NUM_AXES (NUM_AXES)
    ) u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (adv && is_tick),
        .i_ents      (w_res),
        .o_free      (ser_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled with an empty input register");

    a_flip_at_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && is_tick && (r_app_dir[0] != r_req_dir[0])
            && (r_app_duty[0] > signed'({2'b00, r_min})))
        |=> (r_app_dir[0] == $past(r_app_dir[0])))
        else $error("axis 0 direction flipped above the minimum duty");

endmodule
